@@ rtl/qkvspd_pkg.sv @@
package qkvspd_pkg;

  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_PCT = 8'h25;

  // Most results that one input transaction can cause
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);

  typedef enum logic [2:0] {
    KIND_KEY_BYTE   = 3'd0,
    KIND_VALUE_BYTE = 3'd1,
    KIND_KEY_END    = 3'd2,
    KIND_PAIR_END   = 3'd3,
    KIND_STRING_END = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_KEY   = 2'd0,
    PHASE_VALUE = 2'd1
  } pair_phase_t;

  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_FIRST  = 2'd1,
    ESC_SECOND = 2'd2
  } esc_phase_t;

  typedef struct packed {
    pair_phase_t pair_phase;
    logic        segment_nonempty;
    esc_phase_t  escape_phase;
    logic [7:0]  escape_accum;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ rtl/qkvspd_in_if.sv @@
interface qkvspd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (output valid, output data_byte, output byte_valid, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input byte_valid, input last_byte,
                output ready);
endinterface

@@ rtl/qkvspd_out_if.sv @@
interface qkvspd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic       last_of_run;

  modport source (output valid, output out_byte, output kind, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input kind, input last_of_run,
                output ready);
endinterface

@@ rtl/qkvspd_decode.sv @@
module qkvspd_decode
  import qkvspd_pkg::*;
(
  input  parse_state_t st,
  input  logic [7:0]   data_byte,
  input  logic         byte_valid,
  input  logic         last_byte,
  output parse_state_t st_next,
  output logic [CNT_W-1:0] count,
  output result_t      res [MAX_RESULTS]
);

  always_comb begin
    parse_state_t s;
    logic [CNT_W-1:0] n;
    hex_t h;
    logic emit_esc;
    logic emit_raw;
    kind_t byte_kind;

    s         = st;
    n         = '0;
    h         = hex_digit(data_byte);
    emit_esc  = 1'b0;
    emit_raw  = 1'b0;
    byte_kind = (st.pair_phase == PHASE_KEY) ? KIND_KEY_BYTE : KIND_VALUE_BYTE;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '{data: 8'd0, kind: KIND_STRING_END};
    end

    if (byte_valid) begin
      if (data_byte == CH_AMP) begin
        // Pair delimiter: drop any pending escape
        s.escape_phase = ESC_NONE;
        s.escape_accum = 8'd0;
        if (st.pair_phase == PHASE_KEY) begin
          if (st.segment_nonempty) begin
            res[n[IDX_W-1:0]] = '{data: 8'd0, kind: KIND_KEY_END};
            n = n + 1'b1;
            res[n[IDX_W-1:0]] = '{data: 8'd0, kind: KIND_PAIR_END};
            n = n + 1'b1;
          end
        end else begin
          res[n[IDX_W-1:0]] = '{data: 8'd0, kind: KIND_PAIR_END};
          n = n + 1'b1;
          s.pair_phase = PHASE_KEY;
        end
        s.segment_nonempty = 1'b0;
      end else if (data_byte == CH_EQ && st.pair_phase == PHASE_KEY) begin
        s.escape_phase = ESC_NONE;
        s.escape_accum = 8'd0;
        res[n[IDX_W-1:0]] = '{data: 8'd0, kind: KIND_KEY_END};
        n = n + 1'b1;
        s.pair_phase       = PHASE_VALUE;
        s.segment_nonempty = 1'b0;
      end else begin
        if (st.pair_phase == PHASE_KEY) begin
          s.segment_nonempty = 1'b1;
        end
        unique case (st.escape_phase)
          ESC_NONE: begin
            if (data_byte == CH_PCT) begin
              s.escape_phase = ESC_FIRST;
              s.escape_accum = 8'd0;
            end else begin
              emit_raw = 1'b1;
            end
          end
          ESC_FIRST: begin
            if (h.ok) begin
              s.escape_accum = {st.escape_accum[3:0], h.val};
            end
            s.escape_phase = ESC_SECOND;
          end
          ESC_SECOND: begin
            if (h.ok) begin
              s.escape_accum = {st.escape_accum[3:0], h.val};
            end
            emit_esc       = 1'b1;
            s.escape_phase = ESC_NONE;
          end
          default: begin
            // unused phase code: treat as second digit due
            if (h.ok) begin
              s.escape_accum = {st.escape_accum[3:0], h.val};
            end
            emit_esc       = 1'b1;
            s.escape_phase = ESC_NONE;
          end
        endcase
        if (emit_raw) begin
          res[n[IDX_W-1:0]] = '{data: data_byte, kind: byte_kind};
          n = n + 1'b1;
        end
        if (emit_esc) begin
          res[n[IDX_W-1:0]] = '{data: s.escape_accum, kind: byte_kind};
          n = n + 1'b1;
          s.escape_accum = 8'd0;
        end
      end
    end

    if (last_byte) begin
      // Close whatever is open, then mark string end and start over
      if (s.pair_phase == PHASE_KEY) begin
        if (s.segment_nonempty) begin
          res[n[IDX_W-1:0]] = '{data: 8'd0, kind: KIND_KEY_END};
          n = n + 1'b1;
          res[n[IDX_W-1:0]] = '{data: 8'd0, kind: KIND_PAIR_END};
          n = n + 1'b1;
        end
      end else begin
        res[n[IDX_W-1:0]] = '{data: 8'd0, kind: KIND_PAIR_END};
        n = n + 1'b1;
      end
      res[n[IDX_W-1:0]] = '{data: 8'd0, kind: KIND_STRING_END};
      n = n + 1'b1;
      s = '{pair_phase: PHASE_KEY, segment_nonempty: 1'b0,
            escape_phase: ESC_NONE, escape_accum: 8'd0};
    end

    st_next = s;
    count   = n;
  end

endmodule

@@ rtl/query_kv_splitter_pct_decode_top.sv @@
// Latency: an input transaction is registered in the input register, then decoded into the
//   result queue once the queue is free, and its first result is offered from the queue
//   head.
// Throughput: one input transaction per cycle while each causes at most one result and the
//   receiver is ready; an item causing several results holds the decoder until all have left (one output port).
// Reset (rst, synchronous): empties the input and result registers, parser back to key start.
module query_kv_splitter_pct_decode_top
  import qkvspd_pkg::*;
(
  input logic          clk,
  input logic          rst,
  qkvspd_in_if.sink    in_stream,
  qkvspd_out_if.source out_stream
);

  // Input register
  logic       in_vld;
  logic [7:0] in_data;
  logic       in_bval;
  logic       in_last;

  // Parser state, advanced once per decoded transaction
  parse_state_t st;
  parse_state_t st_next;

  // Result queue: holds every result of one transaction, head at entry 0
  result_t          q [MAX_RESULTS];
  logic [CNT_W-1:0] rem;

  result_t          dec_res [MAX_RESULTS];
  logic [CNT_W-1:0] dec_cnt;

  logic pop;
  logic take;
  logic q_free;

  qkvspd_decode u_decode (
    .st         (st),
    .data_byte  (in_data),
    .byte_valid (in_bval),
    .last_byte  (in_last),
    .st_next    (st_next),
    .count      (dec_cnt),
    .res        (dec_res)
  );

  // Queue is free when empty or once its last entry leaves this cycle
  assign pop    = out_stream.valid && out_stream.ready;
  assign q_free = (rem == '0) || (rem == CNT_W'(1) && pop);
  // Move the registered transaction into the queue
  assign take   = in_vld && q_free;

  assign in_stream.ready = !in_vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_stream.valid && in_stream.ready) begin
      in_vld <= 1'b1;
    end else if (take) begin
      in_vld <= 1'b0;
    end
  end

  // Payload: hold unless a new transaction lands
  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      in_data <= in_stream.data_byte;
      in_bval <= in_stream.byte_valid;
      in_last <= in_stream.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{pair_phase: PHASE_KEY, segment_nonempty: 1'b0,
              escape_phase: ESC_NONE, escape_accum: 8'd0};
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (take) begin
      rem <= dec_cnt;
    end else if (pop) begin
      rem <= rem - 1'b1;
    end
  end

  // Load a fresh run, or shift toward the head on each pop
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        q[i] <= dec_res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        q[i] <= q[i+1];
      end
    end
  end

  assign out_stream.valid       = (rem != '0);
  assign out_stream.out_byte    = q[0].data;
  assign out_stream.kind        = 3'(q[0].kind);
  // The final entry of a run closes the run
  assign out_stream.last_of_run = (rem == CNT_W'(1));

endmodule

@@ tb/tb_query_kv_splitter_pct_decode_top.sv @@
`timescale 1ns / 100ps

module tb_query_kv_splitter_pct_decode_top;
  import qkvspd_pkg::*;

  // Run limits: long receiver hold, settle time after drain, watchdog, random items, reports
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 140;
  localparam int unsigned REPORT_LIMIT  = 10;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN   = 2'd0,
    RX_COIN   = 2'd1,
    RX_MOSTLY = 2'd2,
    RX_COMB   = 2'd3
  } rx_mode_t;

  // One expected output transaction
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } token_t;

  logic clk;
  logic rst;

  qkvspd_in_if  in_link();
  qkvspd_out_if out_link();

  query_kv_splitter_pct_decode_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_link),
    .out_stream (out_link)
  );

  // Parser shadow: pair phase, key segment flag and the pending escape
  pair_phase_t shadow_phase;
  logic        shadow_seg_nonempty;
  esc_phase_t  shadow_esc;
  logic [7:0]  shadow_esc_acc;

  // Tokens produced by the current input transaction, then the store of
  // everything still expected on the output
  token_t      run_tokens[$];
  token_t      expected_tokens[$];
  token_t      head_token;

  logic [7:0]  query_bytes[$];

  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          sender_steady;

  // Long-hold handshake between the test sequence and the receiver process
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;
  rx_mode_t    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_tick;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void emit_token(input logic [7:0] d, input kind_t k);
    token_t t;
    t.data = d;
    t.kind = k;
    t.last = 1'b0;
    run_tokens.push_back(t);
  endfunction

  function automatic void clear_escape();
    shadow_esc     = ESC_NONE;
    shadow_esc_acc = 8'h00;
  endfunction

  // Feed one byte through the percent decoder; a non-hex digit still
  // consumes its position but shifts nothing in.
  function automatic void decode_char(input logic [7:0] c, input kind_t k);
    logic [3:0] nib;
    bit         is_hex;
    is_hex = 1'b1;
    nib    = 4'd0;
    if (shadow_esc == ESC_NONE) begin
      if (c == CH_PCT) begin
        shadow_esc     = ESC_FIRST;
        shadow_esc_acc = 8'h00;
      end else begin
        emit_token(c, k);
      end
      return;
    end
    if (c >= 8'h30 && c <= 8'h39) begin
      nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      nib = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
    if (is_hex) shadow_esc_acc = {shadow_esc_acc[3:0], nib};
    if (shadow_esc == ESC_FIRST) begin
      shadow_esc = ESC_SECOND;
    end else begin
      emit_token(shadow_esc_acc, k);
      clear_escape();
    end
  endfunction

  function automatic void reset_parser();
    shadow_phase        = PHASE_KEY;
    shadow_seg_nonempty = 1'b0;
    clear_escape();
  endfunction

  // Work out every result one accepted input transaction causes and queue it
  function automatic void step_parser(input logic [7:0] c, input logic bv,
                                      input logic lb);
    token_t t;
    run_tokens.delete();
    if (bv) begin
      if (shadow_phase == PHASE_KEY) begin
        if (c == CH_AMP) begin
          clear_escape();
          if (shadow_seg_nonempty) begin
            emit_token(8'h00, KIND_KEY_END);
            emit_token(8'h00, KIND_PAIR_END);
          end
          shadow_seg_nonempty = 1'b0;
        end else if (c == CH_EQ) begin
          clear_escape();
          emit_token(8'h00, KIND_KEY_END);
          shadow_phase        = PHASE_VALUE;
          shadow_seg_nonempty = 1'b0;
        end else begin
          shadow_seg_nonempty = 1'b1;
          decode_char(c, KIND_KEY_BYTE);
        end
      end else if (c == CH_AMP) begin
        clear_escape();
        emit_token(8'h00, KIND_PAIR_END);
        shadow_phase        = PHASE_KEY;
        shadow_seg_nonempty = 1'b0;
      end else begin
        decode_char(c, KIND_VALUE_BYTE);
      end
    end
    if (lb) begin
      clear_escape();
      if (shadow_phase == PHASE_KEY) begin
        if (shadow_seg_nonempty) begin
          emit_token(8'h00, KIND_KEY_END);
          emit_token(8'h00, KIND_PAIR_END);
        end
      end else begin
        emit_token(8'h00, KIND_PAIR_END);
      end
      emit_token(8'h00, KIND_STRING_END);
      reset_parser();
    end
    if (run_tokens.size() != 0) begin
      t = run_tokens.pop_back();
      t.last = 1'b1;
      run_tokens.push_back(t);
    end
    foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Checking: compare each output transaction against the oldest
  // expectation, then predict from any input transaction at this edge.
  // Results trail their input through the input register and the result queue, so the order
  // of the two steps inside this block does not matter.
  // ---------------------------------------------------------------------

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("[%0t] MISMATCH %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_parser();
    end else begin
      if (out_link.valid && out_link.ready) begin
        if (expected_tokens.size() == 0) begin
          note_mismatch("result with nothing expected", 0, out_link.kind);
        end else begin
          head_token = expected_tokens.pop_front();
          if (out_link.out_byte !== head_token.data)
            note_mismatch("out_byte", head_token.data, out_link.out_byte);
          if (out_link.kind !== head_token.kind)
            note_mismatch("kind", head_token.kind, out_link.kind);
          if (out_link.last_of_run !== head_token.last)
            note_mismatch("last_of_run", head_token.last, out_link.last_of_run);
        end
      end
      if (in_link.valid && in_link.ready)
        step_parser(in_link.data_byte, in_link.byte_valid, in_link.last_byte);
    end
  end

  // Watchdog: abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $time, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: switch between stall patterns on its own schedule, and
  // serve a long hold whenever the test sequence asks for one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick++;
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 200);
    end else begin
      rx_mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_link.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_link.ready <= 1'b1;
        RX_COIN:   out_link.ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_link.ready <= ($urandom_range(0, 4) != 0);
        default:   out_link.ready <= ((rx_tick % 5) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Offer one input transaction and hold it until accepted; unless the sender is
  // held steady, drop valid for a random gap at the end of a burst.
  task automatic send_item(input logic [7:0] b, input logic bv, input logic lb);
    in_link.valid      <= 1'b1;
    in_link.data_byte  <= b;
    in_link.byte_valid <= bv;
    in_link.last_byte  <= lb;
    @(posedge clk);
    while (!in_link.ready) @(posedge clk);
    if (bv || lb) items_sent++;
    if (sender_steady) return;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_link.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic wait_for_drain();
    in_link.valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  // Send query_bytes as one string; optionally close it with an empty final
  // item and sprinkle in items that carry neither a byte nor an end.
  task automatic send_query(input bit empty_end, input bit sprinkle_idle);
    int unsigned n;
    n = query_bytes.size();
    for (int unsigned i = 0; i < n; i++) begin
      if (sprinkle_idle && $urandom_range(0, 19) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(query_bytes[i], 1'b1, (i == n - 1) && !empty_end);
    end
    if (empty_end || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 7))
      0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
      3:       return 8'h41 + 8'($urandom_range(0, 25));
      4:       return 8'h30 + 8'($urandom_range(0, 9));
      5:       return 8'h2B + 8'($urandom_range(0, 3));
      6:       return 8'h80 + 8'($urandom_range(0, 127));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly hex digits in both cases, with some non-hex bytes mixed in
  function automatic logic [7:0] digit_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'h30 + 8'($urandom_range(0, 9));
      4, 5:       return 8'h61 + 8'($urandom_range(0, 5));
      6, 7:       return 8'h41 + 8'($urandom_range(0, 5));
      8:          return 8'h67 + 8'($urandom_range(0, 19));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_segment(input int unsigned len, input bit allow_eq);
    int unsigned r;
    for (int unsigned j = 0; j < len; j++) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        query_bytes.push_back(CH_PCT);
        query_bytes.push_back(digit_char());
        query_bytes.push_back(digit_char());
      end else if (r == 3 && allow_eq) begin
        query_bytes.push_back(CH_EQ);
      end else begin
        query_bytes.push_back(plain_char());
      end
    end
  endfunction

  // Build a random query: mostly well-formed key/value lists with random
  // content, some pure noise, some with a cut-short escape at the end.
  function automatic void build_query();
    int unsigned n_pairs;
    query_bytes.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 5))
          0:       query_bytes.push_back(CH_AMP);
          1:       query_bytes.push_back(CH_EQ);
          2:       query_bytes.push_back(CH_PCT);
          default: query_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    n_pairs = $urandom_range(0, 4);
    for (int unsigned p = 0; p < n_pairs; p++) begin
      if (p != 0) query_bytes.push_back(CH_AMP);
      if ($urandom_range(0, 4) == 0) query_bytes.push_back(CH_AMP);
      add_segment($urandom_range(0, 4), 1'b0);
      if ($urandom_range(0, 4) != 0) begin
        query_bytes.push_back(CH_EQ);
        add_segment($urandom_range(0, 5), 1'b1);
      end
    end
    if ($urandom_range(0, 4) == 0) query_bytes.push_back(CH_AMP);
    if ($urandom_range(0, 5) == 0) begin
      query_bytes.push_back(CH_PCT);
      if ($urandom_range(0, 1) == 1) query_bytes.push_back(digit_char());
    end
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Skipped empty segment, cut escape before '=', escape of two non-hex
  // digits in a value giving a zero byte, top byte value, closing '&'.
  task automatic test_delimiters();
    query_bytes = '{CH_AMP, 8'h61, CH_PCT, 8'h34, CH_EQ, CH_PCT, CH_PCT, CH_EQ,
                    8'hFF, CH_AMP};
    send_query(1'b0, 1'b0);
  endtask

  // Empty key before '=' at the end of a string, then a string with no bytes
  task automatic test_empty_strings();
    query_bytes = '{CH_EQ};
    send_query(1'b0, 1'b0);
    query_bytes.delete();
    send_query(1'b1, 1'b0);
  endtask

  // Zero raw key byte, an escape split by an item carrying no byte, a
  // non-hex second digit, and a last byte causing four results.
  task automatic test_escapes_and_fanout();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(CH_PCT, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h31, 1'b1, 1'b0);
    send_item(8'h47, 1'b1, 1'b0);
    send_item(8'h5A, 1'b1, 1'b1);
  endtask

  // Mixed-case hex escape in a value, then an escape cut short by the end
  task automatic test_cut_escape_at_end();
    query_bytes = '{8'h76, CH_EQ, CH_PCT, 8'h61, 8'h46, CH_PCT, 8'h32};
    send_query(1'b0, 1'b0);
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering, so the block fills up and stalls its input.
  task automatic test_receiver_hold();
    int unsigned start_count;
    start_count   = items_sent;
    sender_steady = 1'b1;
    hold_requests++;
    while (items_sent - start_count < 40) begin
      build_query();
      send_query($urandom_range(0, 5) == 0, 1'b1);
    end
    sender_steady = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_random_strings();
    int unsigned start_count;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      build_query();
      send_query($urandom_range(0, 5) == 0, 1'b1);
      // Pause now and then until all results are back
      if ($urandom_range(0, 15) == 0) wait_for_drain();
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    in_link.valid      = 1'b0;
    in_link.data_byte  = 8'h00;
    in_link.byte_valid = 1'b0;
    in_link.last_byte  = 1'b0;
    out_link.ready     = 1'b0;
    mismatch_count     = 0;
    items_sent         = 0;
    cycle_count        = 0;
    burst_left         = 0;
    sender_steady      = 1'b0;
    hold_requests      = 0;
    hold_served        = 0;
    hold_left          = 0;
    rx_mode            = RX_OPEN;
    rx_mode_left       = 0;
    rx_tick            = 0;
    reset_parser();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_delimiters();
    test_empty_strings();
    test_escapes_and_fanout();
    test_cut_escape_at_end();
    wait_for_drain();
    test_receiver_hold();
    test_random_strings();

    // Drain, then give the pipeline time to show any stray result
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/qkvspd_pkg.sv
rtl/qkvspd_in_if.sv
rtl/qkvspd_out_if.sv
rtl/qkvspd_decode.sv
rtl/query_kv_splitter_pct_decode_top.sv
tb/tb_query_kv_splitter_pct_decode_top.sv
